// File: sv/bsp_pkg.sv
// Shared types and constants for the bit stream packer.
// Holds the item field layout, op codes, controller states and the
// command/status structs between controller and datapath. No dependencies.
package bsp_pkg;

    localparam int OP_W   = 2;
    localparam int CNT_W  = 4;
    localparam int DATA_W = 8;
    localparam int POS_W  = 15;
    localparam int CAP_W  = 15;

    localparam logic [CAP_W-1:0] CAP_RESET = 15'd9600;
    localparam logic [CNT_W-1:0] MAX_COUNT = 4'd8;

    // Input item layout in s_tdata, lowest field first
    localparam int S_TDATA_W = 32;
    localparam int OP_LSB    = 0;
    localparam int CNT_LSB   = OP_LSB + OP_W;
    localparam int WDATA_LSB = CNT_LSB + CNT_W;
    localparam int NPOS_LSB  = WDATA_LSB + DATA_W;

    // Result item layout in m_tdata, lowest field first
    localparam int M_TDATA_W = 24;

    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_SEEK  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LO,
        ST_HI,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load_item;  // capture the accepted item
        logic rd_en;      // launch a store read
        logic rd_hi;      // read the byte after the current one
        logic wr_lo;      // write back the current byte
        logic wr_hi;      // write the spill byte
        logic load_out;   // commit result and position
    } cmd_t;

    typedef struct packed {
        logic need_hi;    // access crosses into the next byte
        logic out_free;   // output register can take a result
    } sts_t;

endpackage

// File: sv/bsp_ctrl.sv
// Controller for the bit stream packer: sequences the store accesses of
// one item and hands the result to the output register.
// Depends on bsp_pkg.
module bsp_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  bsp_pkg::sts_t  sts,
    output bsp_pkg::cmd_t  cmd
);

    bsp_pkg::state_t state_reg;
    bsp_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bsp_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            bsp_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    // fetch the current byte while the item is captured
                    cmd.load_item = 1'b1;
                    cmd.rd_en     = 1'b1;
                    state_next    = bsp_pkg::ST_LO;
                end
            end
            bsp_pkg::ST_LO: begin
                cmd.wr_lo = 1'b1;
                if (sts.need_hi) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_hi  = 1'b1;
                    state_next = bsp_pkg::ST_HI;
                end else if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = bsp_pkg::ST_IDLE;
                end else begin
                    state_next = bsp_pkg::ST_DONE;
                end
            end
            bsp_pkg::ST_HI: begin
                cmd.wr_hi = 1'b1;
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = bsp_pkg::ST_IDLE;
                end else begin
                    state_next = bsp_pkg::ST_DONE;
                end
            end
            bsp_pkg::ST_DONE: begin
                // hold until the output register frees up
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = bsp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bsp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: sv/bsp_datapath.sv
// Datapath for the bit stream packer: byte store, bit position, capacity
// register, bit alignment and the output register.
// Depends on bsp_pkg; driven by bsp_ctrl through cmd_t / sts_t.
module bsp_datapath #(
    parameter int STORE_BYTES = 2048
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [bsp_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bsp_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                            cfg_valid,
    input  logic [bsp_pkg::CAP_W-1:0]       cfg_data,
    input  bsp_pkg::cmd_t                   cmd,
    output bsp_pkg::sts_t                   sts
);

    localparam int ADDR_W     = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int STORE_BITS = STORE_BYTES * 8;
    localparam int BIDX_W     = bsp_pkg::POS_W - 3;

    logic [bsp_pkg::OP_W-1:0]   op_reg;
    logic [bsp_pkg::CNT_W-1:0]  cnt_reg;
    logic [bsp_pkg::DATA_W-1:0] wdata_reg;
    logic [bsp_pkg::POS_W-1:0]  npos_reg;
    logic [bsp_pkg::POS_W-1:0]  pos_reg;
    logic [bsp_pkg::CAP_W-1:0]  cap_reg;

    logic [7:0] store_mem [STORE_BYTES];
    logic [7:0] rd_data_reg;
    logic [7:0] lo_reg;

    logic                       out_valid_reg;
    logic                       out_ok_reg;
    logic [7:0]                 out_rdata_reg;
    logic [bsp_pkg::POS_W-1:0]  out_pos_reg;

    logic [BIDX_W-1:0]          bidx;
    logic [2:0]                 off;
    logic [bsp_pkg::POS_W:0]    end_pos;
    logic                       fits;
    logic                       is_rw;
    logic                       access;
    logic                       spill;
    logic                       lo_in_store;
    logic                       hi_in_store;
    logic [ADDR_W-1:0]          addr_lo;
    logic [ADDR_W-1:0]          addr_hi;
    logic [15:0]                cmask;
    logic [15:0]                shifted;
    logic [7:0]                 keep_mask;
    logic [15:0]                word;
    logic [15:0]                word_sh;
    logic                       wr_en;
    logic [ADDR_W-1:0]          wr_addr;
    logic [7:0]                 wr_data;
    logic [ADDR_W-1:0]          rd_addr;
    logic                       res_ok;
    logic [7:0]                 res_rdata;
    logic [bsp_pkg::POS_W-1:0]  res_pos;

    // Item capture
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            op_reg    <= s_tdata[bsp_pkg::OP_LSB    +: bsp_pkg::OP_W];
            cnt_reg   <= s_tdata[bsp_pkg::CNT_LSB   +: bsp_pkg::CNT_W];
            wdata_reg <= s_tdata[bsp_pkg::WDATA_LSB +: bsp_pkg::DATA_W];
            npos_reg  <= s_tdata[bsp_pkg::NPOS_LSB  +: bsp_pkg::POS_W];
        end
    end

    // Access geometry and capacity check
    always_comb begin
        bidx        = pos_reg[bsp_pkg::POS_W-1:3];
        off         = pos_reg[2:0];
        end_pos     = {1'b0, pos_reg} + (bsp_pkg::POS_W+1)'(cnt_reg);
        fits        = (end_pos <= {1'b0, cap_reg}) && (32'(end_pos) <= STORE_BITS);
        is_rw       = (op_reg == bsp_pkg::OP_WRITE) || (op_reg == bsp_pkg::OP_READ);
        access      = is_rw && (cnt_reg <= bsp_pkg::MAX_COUNT) && fits;
        spill       = (5'(off) + 5'(cnt_reg)) > 5'd8;
        lo_in_store = 32'(bidx) < STORE_BYTES;
        hi_in_store = (32'(bidx) + 32'd1) < STORE_BYTES;
        addr_lo     = ADDR_W'(bidx);
        addr_hi     = ADDR_W'({1'b0, bidx} + (BIDX_W+1)'(1));
    end

    // Bit alignment for both directions
    always_comb begin
        cmask     = (16'd1 << cnt_reg) - 16'd1;
        shifted   = ({8'h00, wdata_reg} & cmask) << off;
        keep_mask = (8'd1 << off) - 8'd1;
        // lo byte sits in lo_reg once the hi byte has been fetched
        word      = spill ? {rd_data_reg, lo_reg} : {8'h00, rd_data_reg};
        word_sh   = word >> off;
    end

    // Store ports
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = addr_lo;
        wr_data = (rd_data_reg & keep_mask) | shifted[7:0];
        if (op_reg == bsp_pkg::OP_WRITE && access) begin
            if (cmd.wr_lo && lo_in_store) begin
                wr_en = 1'b1;
            end else if (cmd.wr_hi && spill && hi_in_store) begin
                wr_en   = 1'b1;
                wr_addr = addr_hi;
                wr_data = shifted[15:8];
            end
        end
        rd_addr = cmd.rd_hi ? addr_hi : addr_lo;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_hi) begin
            lo_reg <= rd_data_reg;
        end
    end

    // Result
    always_comb begin
        res_ok    = 1'b0;
        res_rdata = 8'h00;
        res_pos   = pos_reg;
        if (op_reg == bsp_pkg::OP_SEEK) begin
            res_ok  = 1'b1;
            res_pos = npos_reg;
        end else if (access) begin
            res_ok  = 1'b1;
            res_pos = end_pos[bsp_pkg::POS_W-1:0];
            if (op_reg == bsp_pkg::OP_READ) begin
                res_rdata = word_sh[7:0] & cmask[7:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            cap_reg       <= bsp_pkg::CAP_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                cap_reg <= cfg_data;
            end
            if (cmd.load_out) begin
                pos_reg       <= res_pos;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_ok_reg    <= res_ok;
            out_rdata_reg <= res_rdata;
            out_pos_reg   <= res_pos;
        end
    end

    assign sts.need_hi  = access && spill;
    assign sts.out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_pos_reg, out_rdata_reg, out_ok_reg};

endmodule

// File: sv/bit_stream_packer.sv
// Bit stream packer: one result item per input item.
// Sequence: an accepted item moves the controller to ST_LO, and an access that spans
// two bytes then to ST_HI; the result is loaded into the output register from there, or
// from ST_DONE while the last result still waits on m_tready. s_tready is high only in
// ST_IDLE, so a new item is taken only once the last one is done. Reset (aresetn low,
// synchronous): position 0, capacity 9600, output empty; store undefined until written.
module bit_stream_packer #(
    parameter int STORE_BYTES = 2048
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [1:0] op, [5:2] bit_count, [13:6] write_data, [28:14] new_position
    input  logic [bsp_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [0] ok, [8:1] read_data, [23:9] position
    output logic [bsp_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bsp_pkg::CAP_W-1:0]       cfg_data
);

    bsp_pkg::cmd_t cmd;
    bsp_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    bsp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bsp_datapath #(
        .STORE_BYTES (STORE_BYTES)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

// File: tb/sv/packer_check_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the bit stream packer testbench: item and result types, a
// bit-level model of the byte store and the queue of results it expects.
// Depends on bsp_pkg for field widths, op codes and the capacity reset value.
package packer_check_pkg;
    import bsp_pkg::*;

    localparam int STORE_BYTES = 2048;
    localparam int STORE_BITS  = STORE_BYTES * 8;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // Field order matches s_tdata, lowest field last in the declaration
    typedef struct packed {
        logic [POS_W-1:0]  new_pos;
        logic [DATA_W-1:0] wdata;
        logic [CNT_W-1:0]  count;
        logic [OP_W-1:0]   op;
    } packer_item_t;

    // Field order matches m_tdata
    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] rdata;
        logic              ok;
    } packer_result_t;

    class packer_scoreboard;
        logic [DATA_W-1:0] store [STORE_BYTES];
        bit                written [STORE_BYTES];
        int unsigned       written_bytes [$];
        logic [POS_W-1:0]  position;
        logic [CAP_W-1:0]  capacity;
        packer_result_t    expected_results [$];
        int unsigned       mismatches;

        function new();
            position   = '0;
            capacity   = CAP_RESET;
            mismatches = 0;
        endfunction

        function int unsigned access_limit();
            return (capacity < STORE_BITS) ? capacity : STORE_BITS;
        endfunction

        function void set_capacity(logic [CAP_W-1:0] value);
            capacity = value;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function bit is_defined(int unsigned idx);
            return idx >= STORE_BYTES || written[idx];
        endfunction

        function logic [DATA_W-1:0] byte_at(int unsigned idx);
            return (idx < STORE_BYTES) ? store[idx] : 8'h00;
        endfunction

        function void store_byte(int unsigned idx, logic [DATA_W-1:0] value);
            store[idx] = value;
            if (!written[idx]) begin
                written[idx] = 1'b1;
                written_bytes.push_back(idx);
            end
        endfunction

        // True unless the item would depend on store bytes that were never written
        function bit access_is_safe(packer_item_t it);
            int unsigned finish;
            int unsigned idx;
            int unsigned off;
            if (!((it.op == OP_WRITE || it.op == OP_READ) && it.count <= MAX_COUNT))
                return 1'b1;
            finish = position + it.count;
            if (finish > access_limit())
                return 1'b1;
            idx = position >> 3;
            off = position[2:0];
            if (it.op == OP_WRITE)
                return off == 0 || is_defined(idx);
            return is_defined(idx) && (off + it.count <= 8 || is_defined(idx + 1));
        endfunction

        // Bit position somewhere inside a byte already written, else the start of the current byte
        function logic [POS_W-1:0] seek_into_store();
            int unsigned idx;
            if (written_bytes.size() == 0)
                return {position[POS_W-1:3], 3'b000};
            idx = written_bytes[$urandom_range(written_bytes.size() - 1)];
            return POS_W'(idx * 8 + $urandom_range(7));
        endfunction

        function packer_result_t predict_access(packer_item_t it);
            packer_result_t    res;
            int unsigned       finish;
            int unsigned       idx;
            int unsigned       off;
            logic [DATA_W-1:0] mask;
            logic [DATA_W-1:0] payload;
            logic [15:0]       window;
            res = '0;
            if (it.op == OP_SEEK) begin
                position = it.new_pos;
                res.ok   = 1'b1;
            end else if ((it.op == OP_WRITE || it.op == OP_READ) && it.count <= MAX_COUNT) begin
                finish = position + it.count;
                if (finish <= access_limit()) begin
                    idx  = position >> 3;
                    off  = position[2:0];
                    mask = 8'((16'd1 << it.count) - 16'd1);
                    if (it.op == OP_WRITE) begin
                        payload = it.wdata & mask;
                        // keep the bits below the position, clear those above
                        if (idx < STORE_BYTES)
                            store_byte(idx, (store[idx] & 8'((9'd1 << off) - 9'd1))
                                            | 8'(payload << off));
                        if (off + it.count > 8 && idx + 1 < STORE_BYTES)
                            store_byte(idx + 1, payload >> (8 - off));
                    end else begin
                        window = {(off + it.count > 8) ? byte_at(idx + 1) : 8'h00,
                                  byte_at(idx)};
                        res.rdata = 8'(window >> off) & mask;
                    end
                    position = POS_W'(finish);
                    res.ok   = 1'b1;
                end
            end
            res.pos = position;
            return res;
        endfunction

        function void note_input(packer_item_t it);
            expected_results.push_back(predict_access(it));
        endfunction

        task report(string what);
            $display("mismatch: %s", what);
            mismatches++;
        endtask

        task check_result(logic [M_TDATA_W-1:0] word);
            packer_result_t got;
            packer_result_t want;
            got = packer_result_t'(word);
            if (expected_results.size() == 0) begin
                report($sformatf("result %h arrived with nothing expected", word));
                return;
            end
            want = expected_results.pop_front();
            if (got.ok !== want.ok)
                report($sformatf("ok %b, expected %b", got.ok, want.ok));
            if (got.rdata !== want.rdata)
                report($sformatf("read_data %h, expected %h", got.rdata, want.rdata));
            if (got.pos !== want.pos)
                report($sformatf("position %0d, expected %0d", got.pos, want.pos));
        endtask
    endclass

endpackage

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// Top-level testbench for bit_stream_packer: drives items and capacity writes
// with random idling and checks each result. Needs bsp_pkg, packer_check_pkg, RTL.
module testbench;
    import bsp_pkg::*;
    import packer_check_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASES        = 7;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CAP_W-1:0]     cfg_data  = '0;

    bit               idling      = 1'b1;
    int unsigned      items_sent  = 0;
    int unsigned      cycle_count = 0;
    packer_scoreboard sb          = new();

    bit_stream_packer #(
        .STORE_BYTES(STORE_BYTES)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // Sample the handshake as it stood at the edge, then pick the next stall
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
        m_tready <= !(idling && $urandom_range(99) < 20);
    end

    function automatic packer_item_t make_item(logic [OP_W-1:0] op, logic [CNT_W-1:0] count,
                                               logic [DATA_W-1:0] wdata,
                                               logic [POS_W-1:0] new_pos);
        packer_item_t it;
        it.op      = op;
        it.count   = count;
        it.wdata   = wdata;
        it.new_pos = new_pos;
        return it;
    endfunction

    // Replace an unsafe access by a seek: to the current byte start for a write, into a written byte for a read
    function automatic packer_item_t legalise(packer_item_t it);
        if (sb.access_is_safe(it))
            return it;
        if (it.op == OP_WRITE)
            it.new_pos = {sb.position[POS_W-1:3], 3'b000};
        else
            it.new_pos = sb.seek_into_store();
        it.op = OP_SEEK;
        return it;
    endfunction

    function automatic packer_item_t random_item();
        packer_item_t it;
        int unsigned  roll;
        int unsigned  lim;
        it   = make_item(OP_WRITE, CNT_W'($urandom_range(8)), DATA_W'($urandom),
                         POS_W'($urandom));
        roll = $urandom_range(99);
        lim  = sb.access_limit();
        if (roll < 40) begin
            it.op = OP_WRITE;
        end else if (roll < 72) begin
            it.op = OP_READ;
        end else if (roll < 87) begin
            it.op = OP_SEEK;
            case ($urandom_range(3))
                0, 1: it.new_pos = sb.seek_into_store();
                2: it.new_pos = POS_W'(lim + 3 - $urandom_range(19));
                default: it.new_pos = POS_W'($urandom);
            endcase
        end else if (roll < 94) begin
            it.op = OP_UNUSED;
            it.count = CNT_W'($urandom);
        end else begin
            it.op    = $urandom_range(1) ? OP_READ : OP_WRITE;
            it.count = CNT_W'($urandom_range(15, 9));
        end
        return it;
    endfunction

    task automatic send_item(input packer_item_t it);
        while (idling && $urandom_range(99) < 20) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tdata  <= S_TDATA_W'(it);
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(it);
        items_sent++;
    endtask

    // Write a run of fields from one position, then read them back in order
    task automatic run_packet();
        logic [CNT_W-1:0] counts [$];
        int unsigned      start;
        int unsigned      n;
        start = $urandom_range(sb.access_limit() / 8) * 8;
        n     = $urandom_range(12, 1);
        send_item(make_item(OP_SEEK, CNT_W'($urandom), DATA_W'($urandom), POS_W'(start)));
        repeat (n) begin
            counts.push_back(($urandom_range(3) == 0) ? MAX_COUNT : CNT_W'($urandom_range(8)));
            send_item(legalise(make_item(OP_WRITE, counts[$], DATA_W'($urandom),
                                         POS_W'($urandom))));
        end
        send_item(make_item(OP_SEEK, CNT_W'($urandom), DATA_W'($urandom), POS_W'(start)));
        foreach (counts[i])
            send_item(legalise(make_item(OP_READ, counts[i], DATA_W'($urandom),
                                         POS_W'($urandom))));
    endtask

    // Drop valid and wait until every result is back
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending() > 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        sb.set_capacity(value);
    endtask

    initial begin
        packer_item_t     directed [$];
        logic [CAP_W-1:0] capacities [PHASES];
        int unsigned      budgets [PHASES];
        int unsigned      target;

        capacities = '{CAP_RESET, 15'd16384, 15'd0, 15'h7FFF, 15'd37,
                       CAP_W'($urandom_range(16384)), CAP_RESET};
        budgets    = '{400, 350, 80, 350, 150, 300, 100};

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        directed = '{
            make_item(OP_WRITE,  4'd8,  8'hFF, 15'd0),
            make_item(OP_WRITE,  4'd3,  8'hFF, 15'd0),     // data wider than count
            make_item(OP_WRITE,  4'd8,  8'hA5, 15'd0),     // spills into next byte
            make_item(OP_WRITE,  4'd0,  8'hFF, 15'd0),     // zero length clears above
            make_item(OP_WRITE,  4'd5,  8'h1F, 15'd0),
            make_item(OP_SEEK,   4'd0,  8'h00, 15'd0),
            make_item(OP_READ,   4'd8,  8'h00, 15'd0),
            make_item(OP_READ,   4'd3,  8'h00, 15'd0),
            make_item(OP_READ,   4'd8,  8'h00, 15'd0),
            make_item(OP_READ,   4'd0,  8'h00, 15'd0),
            make_item(OP_READ,   4'd5,  8'h00, 15'd0),
            make_item(OP_WRITE,  4'd9,  8'hFF, 15'd0),     // count above eight
            make_item(OP_READ,   4'd15, 8'h00, 15'd0),
            make_item(OP_UNUSED, 4'd4,  8'hFF, 15'h7FFF),
            make_item(OP_SEEK,   4'd0,  8'h00, 15'd9592),
            make_item(OP_WRITE,  4'd8,  8'h3C, 15'd0),     // ends on the capacity
            make_item(OP_WRITE,  4'd1,  8'h01, 15'd0),
            make_item(OP_WRITE,  4'd0,  8'hFF, 15'd0),
            make_item(OP_READ,   4'd0,  8'h00, 15'd0),
            make_item(OP_SEEK,   4'd0,  8'h00, 15'd9596),
            make_item(OP_READ,   4'd4,  8'h00, 15'd0),
            make_item(OP_READ,   4'd5,  8'h00, 15'd0),
            make_item(OP_SEEK,   4'd0,  8'h00, 15'h7FFF),  // past the capacity
            make_item(OP_WRITE,  4'd0,  8'h00, 15'd0),
            make_item(OP_READ,   4'd1,  8'h00, 15'd0),
            make_item(OP_SEEK,   4'hF,  8'hFF, 15'd0)
        };
        foreach (directed[i])
            send_item(legalise(directed[i]));

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase > 0) begin
                settle();
                write_capacity(capacities[phase]);
            end
            // one whole phase runs with both sides at full rate
            idling = (phase != 1);
            target = items_sent + budgets[phase];
            while (items_sent < target) begin
                if ($urandom_range(99) < 55)
                    run_packet();
                else
                    send_item(legalise(random_item()));
            end
        end

        settle();
        if (sb.mismatches == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
